FILE: rtl/dqti_pkg.sv
// Package with the shared widths, defaults and entry type of the delta queue timer.
`timescale 1ns / 1ps

package dqti_pkg;

  // Default number of entries in the delta list.
  localparam int MAX_ENTRIES_DEF = 64;

  // Field widths fixed by the interface.
  localparam int TASK_W = 8;
  localparam int TIME_W = 32;

  // One stored entry: the task id and its delta beyond the predecessor.
  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] delta;
  } entry_t;

endpackage

FILE: rtl/dqti_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`timescale 1ns / 1ps

module dqti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/delta_queue_timer_insert.sv
// Top level of the delta queue timer insert block.
`timescale 1ns / 1ps

// Inserts one task into a delta list of up to MAX_ENTRIES waiting tasks held
// in a single RAM of {task id, delta} words. Each beat on the input walks the
// list from the head, one entry per cycle through the RAM read port, until it
// finds the first entry whose delta exceeds the remaining delay, then shifts
// the later entries up one place, one entry per cycle through the write port.
// A dropped insert on a full list and an insert into an empty list skip the
// walk. Only one insert is in work at a time, but the next beat is taken
// while a result still waits in the output register.
module delta_queue_timer_insert
  import dqti_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TASK_W-1:0] task_id,
  input  logic [TIME_W-1:0] delay,
  input  logic [TIME_W-1:0] elapsed,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TIME_W-1:0] notify_time,
  output logic              became_head,
  output logic              full_res
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  k;
  logic [TASK_W-1:0] id;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] elap;
  entry_t            carry;
  logic [TIME_W-1:0] res_notify;
  logic              res_head;
  logic              res_full;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;

  logic              in_acc;
  logic [CNT_W-1:0]  k1;
  logic              last;
  logic              is_full;
  logic [TIME_W-1:0] d_eff;
  logic              walk_past;
  logic [TIME_W-1:0] rem_sub;
  logic [TIME_W-1:0] delta_cut;

  dqti_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Handshake and walk arithmetic.
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign k1        = k + CNT_W'(1);
  assign last      = (k1 == count);
  assign is_full   = (count == CNT_W'(MAX_ENTRIES));
  // The head's delta is seen reduced by the elapsed ticks.
  assign d_eff     = (k == '0) ? (ram_rdata.delta - elap) : ram_rdata.delta;
  assign walk_past = (rem >= d_eff);
  assign rem_sub   = rem - d_eff;
  assign delta_cut = d_eff - rem;

  // RAM port control: reads run one entry ahead of the write.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k[IDX_W-1:0];
    ram_wdata = '{task_id: id, delta: rem};
    ram_raddr = k1[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        ram_raddr = '0;
        ram_waddr = '0;
        ram_wdata = '{task_id: task_id, delta: delay};
        ram_we    = in_acc && (count == '0);
      end
      S_WALK: begin
        ram_we = 1'b1;
        if (walk_past) begin
          if (last) begin
            ram_waddr = count[IDX_W-1:0];
            ram_wdata = '{task_id: id, delta: rem_sub};
          end else begin
            ram_we = 1'b0;
          end
        end
      end
      S_SHIFT: begin
        // The entry two above the current one is fetched before it is overwritten.
        ram_we    = 1'b1;
        ram_waddr = k1[IDX_W-1:0];
        ram_wdata = carry;
        ram_raddr = k1[IDX_W-1:0] + IDX_W'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer, entry count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            id   <= task_id;
            rem  <= delay;
            elap <= elapsed;
            k    <= '0;
            if (is_full) begin
              res_notify <= '0;
              res_head   <= 1'b0;
              res_full   <= 1'b1;
              state      <= S_FIN;
            end else if (count == '0) begin
              count      <= CNT_W'(1);
              res_notify <= delay;
              res_head   <= 1'b1;
              res_full   <= 1'b0;
              state      <= S_FIN;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (walk_past) begin
            rem <= rem_sub;
            if (last) begin
              // Goes at the tail; the head keeps its original delta.
              count      <= count + CNT_W'(1);
              res_notify <= '0;
              res_head   <= 1'b0;
              res_full   <= 1'b0;
              state      <= S_FIN;
            end else begin
              k <= k1;
            end
          end else begin
            // Found the first larger entry: it moves up with its delta cut.
            carry      <= '{task_id: ram_rdata.task_id, delta: delta_cut};
            res_notify <= (k == '0) ? rem : '0;
            res_head   <= (k == '0);
            res_full   <= 1'b0;
            state      <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (last) begin
            count <= count + CNT_W'(1);
            state <= S_FIN;
          end else begin
            carry <= ram_rdata;
            k     <= k1;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            notify_time <= res_notify;
            became_head <= res_head;
            full_res    <= res_full;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
